// File: src/irrigation_pump_interlock_controller_core_macros.svh
// Assertion helpers for the pump interlock controller.
`ifndef IRRIGATION_PUMP_INTERLOCK_CONTROLLER_CORE_MACROS_SVH
`define IRRIGATION_PUMP_INTERLOCK_CONTROLLER_CORE_MACROS_SVH

// Check that a condition implies a property on the same clock edge.
`define IPIC_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property on the next clock edge.
`define IPIC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: src/ipic_pkg.sv
package ipic_pkg;

  localparam int unsigned NodesDef   = 32;
  localparam int unsigned MoistMax   = 25600;
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned MsPerMin   = 60000;

  localparam int unsigned InW  = 96;
  localparam int unsigned OutW = 32;
  localparam int unsigned SumW = 23;

  typedef enum logic [2:0] {
    KIND_SAMPLE = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_MAN_ON = 3'd3,
    KIND_MAN_OFF = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    OC_START   = 4'd0,
    OC_STOP    = 4'd1,
    OC_ABOVE   = 4'd2,
    OC_NOFRESH = 4'd3,
    OC_FEW     = 4'd4,
    OC_LOCK    = 4'd5,
    OC_INTERVAL = 4'd6,
    OC_FLOAT   = 4'd7,
    OC_DISABLED = 4'd8
  } outcome_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    ADDR_AUTO     = 3'd0,
    ADDR_STALE    = 3'd1,
    ADDR_QUORUM   = 3'd2,
    ADDR_TRIGGER  = 3'd3,
    ADDR_INTERVAL = 3'd4,
    ADDR_RUNTIME  = 3'd5
  } reg_addr_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the accepted word
    logic pre;       // pump pre-check and optional lock
    logic scan_clr;  // clear scan accumulators
    logic scan_step; // accumulate one node
    logic div_init;  // load the divider
    logic div_step;  // one quotient bit
    logic decide;    // final checks and result
    logic direct;    // resolve a non-tick item
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pre_done;  // tick already resolved by pump check or disable
    logic scan_last;
    logic need_div;  // quorum met, average is needed
    logic div_last;
  } sts_t;

endpackage

// File: src/ipic_ctrl.sv
module ipic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [2:0]       kind_i,
  input  logic             out_free_i,
  input  ipic_pkg::sts_t   sts_i,
  output ipic_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             out_set_o
);
  import ipic_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    out_set_o = 1'b0;
    busy_o    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == KIND_TICK) begin
            state_d = ST_SCAN;
            cmd_o.scan_clr = 1'b1;
          end else if (kind_i == KIND_MAN_ON || kind_i == KIND_MAN_OFF) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (!sts_i.pre_done) cmd_o.scan_step = 1'b1;
        if (sts_i.pre_done) begin
          cmd_o.pre = 1'b1;
          state_d = ST_OUT;
        end else if (sts_i.scan_last) begin
          if (sts_i.need_div) begin
            cmd_o.div_init = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          out_set_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// File: src/ipic_dp.sv
module ipic_dp #(
  parameter int unsigned NODES = ipic_pkg::NodesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ipic_pkg::cmd_t   cmd_i,
  input  logic [ipic_pkg::InW-1:0] word_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_addr_i,
  input  logic [31:0]      cfg_data_i,
  output logic [31:0]      cfg_rdata_o,
  output ipic_pkg::sts_t   sts_o,
  output logic [ipic_pkg::OutW-1:0] result_o
);
  import ipic_pkg::*;

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CntW = $clog2(NODES + 1);

  // Configuration registers.
  logic        auto_q;
  logic [15:0] stale_q;
  logic [5:0]  quorum_q;
  logic [6:0]  trig_q;
  logic [15:0] intv_q;
  logic [31:0] runtime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q    <= 1'b0;
      stale_q   <= 16'd300;
      quorum_q  <= 6'd1;
      trig_q    <= 7'd30;
      intv_q    <= 16'd60;
      runtime_q <= 32'd600000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ADDR_AUTO:     auto_q    <= cfg_data_i[0];
        ADDR_STALE:    stale_q   <= cfg_data_i[15:0];
        ADDR_QUORUM:   quorum_q  <= cfg_data_i[5:0];
        ADDR_TRIGGER:  trig_q    <= cfg_data_i[6:0];
        ADDR_INTERVAL: intv_q    <= cfg_data_i[15:0];
        ADDR_RUNTIME:  runtime_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_addr_i)
      ADDR_AUTO:     cfg_rdata_o = {31'd0, auto_q};
      ADDR_STALE:    cfg_rdata_o = {16'd0, stale_q};
      ADDR_QUORUM:   cfg_rdata_o = {26'd0, quorum_q};
      ADDR_TRIGGER:  cfg_rdata_o = {25'd0, trig_q};
      ADDR_INTERVAL: cfg_rdata_o = {16'd0, intv_q};
      ADDR_RUNTIME:  cfg_rdata_o = runtime_q;
      default:       cfg_rdata_o = '0;
    endcase
  end

  // Scaled limits, registered off the config to keep multipliers out of the scan path.
  logic [31:0] fresh_lim_q, intv_ms_q;
  always_ff @(posedge clk_i) begin
    fresh_lim_q <= 32'(stale_q * 32'(MsPerSec));
    intv_ms_q   <= 32'(intv_q * 32'(MsPerMin));
  end

  // Captured word fields.
  logic [2:0]  kind;
  logic [4:0]  node;
  logic [14:0] moist;
  logic [31:0] stime, now;
  logic        onl, water, accepts;
  assign kind    = word_i[2:0];
  assign node    = word_i[7:3];
  assign moist   = word_i[22:8];
  assign stime   = word_i[54:23];
  assign onl     = word_i[55];
  assign now     = word_i[87:56];
  assign water   = word_i[88];
  assign accepts = word_i[89];

  logic [31:0] now_q;
  logic        water_q, accepts_q;

  // Node records.
  logic [NODES-1:0] has_q, onl_q;
  logic [14:0]      nm_q [NODES];
  logic [31:0]      nt_q [NODES];
  logic             node_ok;
  assign node_ok = ({27'd0, node} < 32'(NODES));
  logic [14:0] moist_c;
  assign moist_c = (moist > 15'(MoistMax)) ? 15'(MoistMax) : moist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q <= '0;
      onl_q <= '0;
    end else if (cmd_i.load && node_ok) begin
      if (kind == KIND_SAMPLE) has_q[IdxW'(node)] <= 1'b1;
      if (kind == KIND_STATUS) onl_q[IdxW'(node)] <= onl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && node_ok && kind == KIND_SAMPLE) begin
      nm_q[IdxW'(node)] <= moist_c;
      nt_q[IdxW'(node)] <= stime;
    end
  end

  // Pump state.
  mode_e       mode_q;
  logic        sv_q, lv_q;
  logic [31:0] st_q, lt_q;
  logic [3:0]  oc_q;
  logic [14:0] avg_q;
  logic [CntW-1:0] fresh_q;
  logic        lock_hit;
  logic        pre_done;

  assign lock_hit = (mode_q == MODE_ON) &&
                    ((sv_q && (now_q - st_q) >= runtime_q) || !water_q);
  assign pre_done = lock_hit || (mode_q == MODE_LOCKED) || !auto_q;

  // Scan.
  logic [IdxW-1:0] idx_q;
  logic [SumW-1:0] sum_q;
  logic            fresh_hit;
  assign fresh_hit = has_q[idx_q] && onl_q[idx_q] && ((now_q - nt_q[idx_q]) <= fresh_lim_q);

  // Sum including the node scanned this cycle; feeds the divider on the last node.
  logic [SumW-1:0] sum_d;
  assign sum_d = fresh_hit ? sum_q + {8'd0, nm_q[idx_q]} : sum_q;

  // Restoring divider.
  logic [SumW-1:0] quo_q, rem_q;
  logic [$clog2(SumW+1)-1:0] dcnt_q;
  logic [SumW:0]   rem_sh;
  assign rem_sh = {rem_q, quo_q[SumW-1]};

  logic [31:0] trig_lim;
  assign trig_lim = {17'd0, trig_q, 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
      sv_q   <= 1'b0;
      lv_q   <= 1'b0;
      st_q   <= '0;
      lt_q   <= '0;
    end else begin
      if (cmd_i.pre && lock_hit) begin
        mode_q <= MODE_LOCKED;
        sv_q   <= 1'b0;
      end
      if (cmd_i.load && kind == KIND_MAN_OFF) begin
        mode_q <= MODE_OFF;
        sv_q   <= 1'b0;
      end
      if (cmd_i.load && kind == KIND_MAN_ON && mode_q == MODE_OFF && water && accepts) begin
        mode_q <= MODE_ON;
        sv_q <= 1'b1; st_q <= now;
        lv_q <= 1'b1; lt_q <= now;
      end
      if (cmd_i.decide && fresh_q != '0 && {{(32-CntW){1'b0}}, fresh_q} >= {26'd0, quorum_q}
          && {9'd0, quo_q} < trig_lim && water_q
          && !(lv_q && (now_q - lt_q) < intv_ms_q)
          && mode_q != MODE_ON && accepts_q) begin
        mode_q <= MODE_ON;
        sv_q <= 1'b1; st_q <= now_q;
        lv_q <= 1'b1; lt_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now; water_q <= water; accepts_q <= accepts;
      avg_q <= '0; fresh_q <= '0;
      if (kind == KIND_MAN_OFF) oc_q <= OC_STOP;
      else if (mode_q == MODE_LOCKED) oc_q <= OC_LOCK;
      else if (mode_q == MODE_ON) oc_q <= OC_START;
      else if (!water) oc_q <= OC_FLOAT;
      else if (accepts) oc_q <= OC_START;
      else oc_q <= OC_LOCK;
    end
    if (cmd_i.scan_clr) begin
      idx_q <= '0; sum_q <= '0;
    end
    if (cmd_i.pre) begin
      oc_q <= (lock_hit || mode_q == MODE_LOCKED) ? OC_LOCK : OC_DISABLED;
      fresh_q <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (fresh_hit) begin
        sum_q   <= sum_d;
        fresh_q <= fresh_q + 1'b1;
      end
    end
    if (cmd_i.div_init) begin
      quo_q <= sum_d; rem_q <= '0; dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (rem_sh >= (SumW+1)'(fresh_q)) begin
        rem_q <= SumW'(rem_sh - (SumW+1)'(fresh_q));
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[SumW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
    if (cmd_i.decide) begin
      if (fresh_q == '0) oc_q <= OC_NOFRESH;
      else if ({{(32-CntW){1'b0}}, fresh_q} < {26'd0, quorum_q}) oc_q <= OC_FEW;
      else begin
        avg_q <= quo_q[14:0];
        if ({9'd0, quo_q} >= trig_lim) oc_q <= OC_ABOVE;
        else if (!water_q) oc_q <= OC_FLOAT;
        else if (lv_q && (now_q - lt_q) < intv_ms_q) oc_q <= OC_INTERVAL;
        else if (mode_q != MODE_ON && !accepts_q) oc_q <= OC_LOCK;
        else oc_q <= OC_START;
      end
    end
  end

  assign sts_o.pre_done  = pre_done;
  assign sts_o.scan_last = (32'(idx_q) == 32'(NODES - 1));
  assign sts_o.need_div  = ((fresh_hit ? fresh_q + 1'b1 : fresh_q) != '0) &&
                           ({{(32-CntW){1'b0}}, (fresh_hit ? fresh_q + 1'b1 : fresh_q)}
                            >= {26'd0, quorum_q});
  assign sts_o.div_last  = (32'(dcnt_q) == 32'(SumW - 1));

  logic pon, plk;
  assign pon = (mode_q == MODE_ON);
  assign plk = (mode_q == MODE_LOCKED);
  assign result_o = {5'd0, plk, pon, 6'(fresh_q), avg_q, oc_q};
endmodule

// File: src/irrigation_pump_interlock_controller_core.sv
// Irrigation pump interlock controller. Feed words on the slave stream with the item kind on
// tuser. Samples, node status and unknown kinds are taken in idle and give no result. Tick,
// manual on and manual off each give one result word on the master stream. A full tick runs
// in these steps:
//   - check the running pump for max runtime or a dry tank,
//   - walk the node records one per cycle,
//   - run a restoring divider, one quotient bit per cycle, to form the average,
//   - pass through the decide state, then park the result from the output state.
// A tick that misses the quorum or finds no fresh node skips the divider. A tick settled by
// the lock or disable check skips the scan. Manual on and off go straight to the output
// state. A result word the sink has not taken holds the next result-producing item in its
// output state until the register frees. One item is in flight at a time; the result
// register frees the input as soon as the word is parked there. Configure over APB only
// while idle.
module irrigation_pump_interlock_controller_core #(
  parameter int unsigned NODES = ipic_pkg::NodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: node[4:0] moisture[19:5] sample_time[51:20] online[52] now_time[84:53]
  //        has_water[85] pump_accepts[86], zero fill at 87
  input  logic [87:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: outcome[3:0] avg_moisture[18:4] fresh_nodes[24:19] pump_on[25] pump_locked[26]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ipic_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  logic  busy, out_set, in_fire;
  logic  ovalid_q;
  logic [OutW-1:0] odata_q, result;
  logic [2:0] cfg_addr;
  logic [InW-1:0] in_word;

  assign pready   = 1'b1;
  assign cfg_addr = paddr[4:2];

  // Merge kind and payload into one internal word, kind in the low bits.
  assign in_word = {5'd0, s_axis_tdata, s_axis_tuser};

  // Accept only while the controller idles.
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  ipic_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .kind_i     (s_axis_tuser),
    .out_free_i (!ovalid_q || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .out_set_o  (out_set)
  );

  ipic_dp #(.NODES(NODES)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .word_i      (in_word),
    .cfg_we_i    (psel && penable && pwrite),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (pwdata),
    .cfg_rdata_o (prdata),
    .sts_o       (sts),
    .result_o    (result)
  );

  // Output register: hold the word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_set) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_set) odata_q <= result;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  `include "irrigation_pump_interlock_controller_core_macros.svh"

  `IPIC_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy, !in_fire, "word accepted while busy")
  `IPIC_ASSERT_NEXT(a_out_sets_valid, clk_i, rst_ni, out_set, m_axis_tvalid, "result lost")
  `IPIC_ASSERT_IMP(a_lock_excl, clk_i, rst_ni, m_axis_tvalid,
                   !(m_axis_tdata[25] && m_axis_tdata[26]), "pump on and locked")
endmodule

// File: bench/ipic_checker.sv
module ipic_checker
  import ipic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [95:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [3:0]  outcome;
    logic [14:0] avg;
    logic [5:0]  fresh;
    logic        pump_on;
    logic        pump_locked;
  } verdict_t;

  logic        auto_en;
  logic [15:0] stale_s;
  logic [5:0]  quorum;
  logic [6:0]  trig_pct;
  logic [15:0] interval_min;
  logic [31:0] runtime_ms;

  logic        has_smp [NodesDef];
  logic [14:0] moist   [NodesDef];
  logic [31:0] smp_ms  [NodesDef];
  logic        online  [NodesDef];
  mode_e       mode;
  logic        run_valid;
  logic [31:0] run_start;
  logic        last_valid;
  logic [31:0] last_start;

  verdict_t verdicts_q[$];

  assign pending_o = verdicts_q.size();

  function automatic void start_pump(logic [31:0] now);
    mode = MODE_ON;
    run_valid = 1'b1;
    run_start = now;
    last_valid = 1'b1;
    last_start = now;
  endfunction

  function automatic outcome_e tick_decision(logic [31:0] now, logic water, logic accepts,
                                             inout logic [14:0] avg, inout logic [5:0] fresh);
    logic [31:0] sum;
    logic [31:0] cnt;
    logic [31:0] mean;
    logic [31:0] fresh_lim;
    sum = 0;
    cnt = 0;
    fresh_lim = stale_s * 32'd1000;
    if (mode == MODE_ON) begin
      if ((run_valid && (now - run_start) >= runtime_ms) || !water) begin
        mode = MODE_LOCKED;
        run_valid = 1'b0;
        return OC_LOCK;
      end
    end
    if (mode == MODE_LOCKED) return OC_LOCK;
    if (!auto_en) return OC_DISABLED;
    for (int i = 0; i < NodesDef; i++) begin
      if (has_smp[i] && online[i] && (now - smp_ms[i]) <= fresh_lim) begin
        sum += moist[i];
        cnt++;
      end
    end
    fresh = cnt[5:0];
    if (cnt == 0) return OC_NOFRESH;
    if (cnt < quorum) return OC_FEW;
    mean = sum / cnt;
    avg = mean[14:0];
    if (mean >= trig_pct * 32'd256) return OC_ABOVE;
    if (!water) return OC_FLOAT;
    if (last_valid && (now - last_start) < interval_min * 32'd60000) return OC_INTERVAL;
    if (mode != MODE_ON) begin
      if (!accepts) return OC_LOCK;
      start_pump(now);
    end
    return OC_START;
  endfunction

  task automatic predict_word(logic [95:0] w);
    kind_e       k;
    logic [4:0]  nd;
    logic [14:0] m;
    logic [31:0] now;
    logic        water;
    logic        acc;
    verdict_t    v;
    k = kind_e'(w[2:0]);
    nd = w[7:3];
    m = w[22:8];
    now = w[87:56];
    water = w[88];
    acc = w[89];
    v = '0;
    case (k)
      KIND_SAMPLE: begin
        moist[nd] = (m > MoistMax) ? 15'(MoistMax) : m;
        smp_ms[nd] = w[54:23];
        has_smp[nd] = 1'b1;
        return;
      end
      KIND_STATUS: begin
        online[nd] = w[55];
        return;
      end
      KIND_TICK: v.outcome = tick_decision(now, water, acc, v.avg, v.fresh);
      KIND_MAN_ON: begin
        if (mode == MODE_LOCKED) v.outcome = OC_LOCK;
        else if (mode == MODE_ON) v.outcome = OC_START;
        else if (!water) v.outcome = OC_FLOAT;
        else if (acc) begin
          start_pump(now);
          v.outcome = OC_START;
        end else v.outcome = OC_LOCK;
      end
      KIND_MAN_OFF: begin
        mode = MODE_OFF;
        run_valid = 1'b0;
        v.outcome = OC_STOP;
      end
      default: return;
    endcase
    v.pump_on = (mode == MODE_ON);
    v.pump_locked = (mode == MODE_LOCKED);
    verdicts_q = {verdicts_q, v};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    verdict_t got;
    if (!rst_ni) begin
      auto_en = 0; stale_s = 300; quorum = 1; trig_pct = 30;
      interval_min = 60; runtime_ms = 600000;
      for (int i = 0; i < NodesDef; i++) begin
        has_smp[i] = 0; online[i] = 0; moist[i] = 0; smp_ms[i] = 0;
      end
      mode = MODE_OFF; run_valid = 0; run_start = 0; last_valid = 0; last_start = 0;
      verdicts_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_addr_e'(cfg_addr_i[4:2]))
          ADDR_AUTO:     auto_en = cfg_data_i[0];
          ADDR_STALE:    stale_s = cfg_data_i[15:0];
          ADDR_QUORUM:   quorum = cfg_data_i[5:0];
          ADDR_TRIGGER:  trig_pct = cfg_data_i[6:0];
          ADDR_INTERVAL: interval_min = cfg_data_i[15:0];
          ADDR_RUNTIME:  runtime_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) predict_word(s_data_i);
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[26], m_data_i[25], m_data_i[24:19], m_data_i[18:4], m_data_i[3:0]};
        got.outcome = m_data_i[3:0];
        got.avg = m_data_i[18:4];
        got.fresh = m_data_i[24:19];
        got.pump_on = m_data_i[25];
        got.pump_locked = m_data_i[26];
        if (verdicts_q.size() == 0) begin
          $error("unexpected result word %h", m_data_i);
          fail_count_o++;
        end else begin
          exp_v = verdicts_q.pop_front();
          if (got.outcome != exp_v.outcome) begin
            $error("outcome exp %0d got %0d", exp_v.outcome, got.outcome); fail_count_o++;
          end
          if (got.avg != exp_v.avg) begin
            $error("avg_moisture exp %0d got %0d", exp_v.avg, got.avg); fail_count_o++;
          end
          if (got.fresh != exp_v.fresh) begin
            $error("fresh_nodes exp %0d got %0d", exp_v.fresh, got.fresh); fail_count_o++;
          end
          if (got.pump_on != exp_v.pump_on) begin
            $error("pump_on exp %0d got %0d", exp_v.pump_on, got.pump_on); fail_count_o++;
          end
          if (got.pump_locked != exp_v.pump_locked) begin
            $error("pump_locked exp %0d got %0d", exp_v.pump_locked, got.pump_locked);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_irrigation_pump_interlock_controller_core.sv
module tb_irrigation_pump_interlock_controller_core;
  import ipic_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: node moisture sample_time online now_time has_water pump_accepts, zero fill
  logic [87:0] s_axis_tdata = '0;
  // tuser: kind
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: outcome avg_moisture fresh_nodes pump_on pump_locked
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int idle_cycles;
  bit stim_done;
  bit rx_calm;
  bit rx_hold;
  bit tx_calm;
  logic [31:0] clock_ms;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  irrigation_pump_interlock_controller_core u_top (.*);

  ipic_checker u_chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i({5'd0, s_axis_tdata, s_axis_tuser}),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_addr_i(paddr),
    .cfg_data_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: stall at random with probability 0.27 unless calm; hold fully during a long hold-off.
  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= rx_calm || ($urandom_range(99) >= 27);
  end

  // Long hold-off so the single result register fills and the input stalls.
  initial begin
    rx_hold = 1'b0;
    rx_calm = 1'b0;
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (600) @(posedge clk_i);
    rx_hold = 1'b0;
    rx_calm = 1'b1;
    repeat (8000) @(posedge clk_i);
    rx_calm = 1'b0;
  end

  // Watchdog: count cycles with no word moving on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_addr_e a, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {a, 2'b00}; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain results, then leave room for any sample still being stored.
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic en, logic [15:0] st, logic [5:0] q, logic [6:0] tr,
                                logic [15:0] iv, logic [31:0] rt);
    settle();
    reg_write(ADDR_AUTO, {31'd0, en});
    reg_write(ADDR_STALE, {16'd0, st});
    reg_write(ADDR_QUORUM, {26'd0, q});
    reg_write(ADDR_TRIGGER, {25'd0, tr});
    reg_write(ADDR_INTERVAL, {16'd0, iv});
    reg_write(ADDR_RUNTIME, rt);
  endtask

  // Offer one word; hold it until accepted, idling the sender at random first.
  task automatic send_word(kind_e k, logic [4:0] nd, logic [14:0] m, logic [31:0] st,
                           logic on, logic [31:0] now, logic water, logic acc);
    if (!tx_calm) begin
      while ($urandom_range(99) < 27) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 88'({$urandom, $urandom, $urandom});
        s_axis_tuser <= 3'($urandom);
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, acc, water, now, on, st, m, nd};
    s_axis_tuser <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_word(logic [31:0] step);
    int r;
    logic [4:0] nd;
    logic [14:0] m;
    logic [31:0] st;
    logic [31:0] any;
    logic on;
    logic wat;
    logic acc;
    r = $urandom_range(99);
    nd = 5'($urandom_range(31));
    m = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(MoistMax));
    st = $urandom;
    any = $urandom;
    on = 1'($urandom);
    wat = 1'($urandom);
    acc = 1'($urandom);
    clock_ms += step;
    if (r < 40)
      send_word(KIND_SAMPLE, nd, m, clock_ms - 32'($urandom_range(400000)), on, any,
                wat, acc);
    else if (r < 55)
      send_word(KIND_STATUS, nd, m, st, ($urandom_range(5) != 0), any, wat, acc);
    else if (r < 82)
      send_word(KIND_TICK, nd, m, st, on, clock_ms,
                ($urandom_range(7) != 0), ($urandom_range(7) != 0));
    else if (r < 90)
      send_word(KIND_MAN_ON, nd, m, st, on, clock_ms,
                ($urandom_range(5) != 0), ($urandom_range(5) != 0));
    else if (r < 96)
      send_word(KIND_MAN_OFF, nd, m, st, on, clock_ms, wat, acc);
    else
      send_word(kind_e'(3'($urandom_range(7, 5))), nd, m, st, on, any, wat, acc);
  endtask

  initial begin
    stim_done = 1'b0;
    tx_calm = 1'b0;
    clock_ms = 32'd1000000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: disabled tick, then extremes of fields and every kind.
    send_word(KIND_TICK, 0, 0, 0, 0, 0, 1, 1);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 0, 0, 1);
    stop_sending();
    apply_settings(1, 300, 1, 30, 60, 600000);
    send_word(KIND_TICK, 0, 0, 0, 0, 100, 1, 1);
    send_word(KIND_SAMPLE, 31, 15'h7FFF, 32'hFFFF_FFFF, 0, 0, 1, 1);
    send_word(KIND_STATUS, 31, 0, 0, 1, 0, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd100, 1, 1);
    send_word(KIND_SAMPLE, 0, 0, 32'd50, 0, 0, 1, 1);
    send_word(KIND_STATUS, 0, 0, 0, 1, 0, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd100, 1, 0);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd100, 0, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd200, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd300, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd300, 0, 1);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 32'd400, 1, 1);
    send_word(KIND_MAN_OFF, 0, 0, 0, 0, 32'd500, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd600, 1, 1);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 32'd700, 1, 0);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 32'd800, 1, 1);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 32'd900, 1, 1);
    send_word(kind_e'(3'd7), 5, 0, 0, 1, 0, 1, 1);
    send_word(KIND_MAN_OFF, 0, 0, 0, 0, 32'd1000, 1, 1);
    stop_sending();
    apply_settings(1, 0, 32, 100, 0, 0);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd50, 1, 1);
    send_word(KIND_MAN_ON, 0, 0, 0, 0, 32'd60, 1, 1);
    send_word(KIND_TICK, 0, 0, 0, 0, 32'd60, 1, 1);
    stop_sending();

    // Random phases over a range of settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(1, 300, 1, 50, 1, 600000);
        1: apply_settings(1, 65535, 0, 100, 0, 32'hFFFF_FFFF);
        2: apply_settings(1, 200, 3, 60, 2, 400000);
        3: apply_settings(0, 300, 1, 30, 60, 600000);
        4: apply_settings(1, 100, 32, 0, 65535, 1);
        default: apply_settings(1, 16'($urandom_range(600)), 6'($urandom_range(6)),
                                7'($urandom_range(100)), 16'($urandom_range(3)),
                                32'($urandom_range(2000000)));
      endcase
      tx_calm = (ph == 2);
      for (int n = 0; n < 100; n++) random_word(32'($urandom_range(60000)));
      stop_sending();
    end
    tx_calm = 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/ipic_pkg.sv
src/ipic_ctrl.sv
src/ipic_dp.sv
src/irrigation_pump_interlock_controller_core.sv
bench/ipic_checker.sv
bench/tb_irrigation_pump_interlock_controller_core.sv
